// File: hdl/msst_pkg.sv
// Shared types and constants for the multi-slot software timer.
// Holds the request, mode and result codes, the slot entry layout and the sizes.
// Depends on nothing; used by msst_ram and multi_slot_software_timer.
`default_nettype none

package msst_pkg;

   // Default number of timer slots.
   localparam int unsigned SLOT_COUNT_DEFAULT = 8;

   // At most this many fired results are reported per tick.
   localparam int unsigned RESULT_CAP = 8;
   localparam int unsigned REP_CNT_W  = $clog2(RESULT_CAP + 1);

   // Seconds to milliseconds.
   localparam int unsigned MS_PER_SECOND = 1000;

   // Dividend width: a 32-bit timeout times 1000 fits in 42 bits.
   localparam int unsigned DVD_W     = 42;
   localparam int unsigned REM_W     = 17;
   localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

   // Port widths.
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 40;

   // Request codes carried in tuser.
   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_ADD     = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_IGNORED = 2'd3
   } func_type;

   // Slot modes.
   typedef enum logic [1:0] {
      MODE_FREE          = 2'd0,
      MODE_SINGLE        = 2'd1,
      MODE_CYCLIC        = 2'd2,
      MODE_SINGLE_CYCLIC = 2'd3
   } mode_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_FIRED    = 3'd2,
      KIND_IDLE     = 3'd3,
      KIND_CLEARED  = 3'd4
   } kind_type;

   // One slot as stored in the slot memory.
   typedef struct packed {
      logic [31:0] repeat_cmp;
      logic [31:0] first_cmp;
      logic [31:0] count;
   } slot_entry_type;

   localparam int unsigned ENTRY_W = $bits(slot_entry_type);

endpackage

`default_nettype wire

// File: hdl/msst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; defaults come from msst_pkg.
`default_nettype none

module msst_ram #(
   parameter int unsigned WIDTH = msst_pkg::ENTRY_W,
   parameter int unsigned DEPTH = msst_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/multi_slot_software_timer.sv
// Multi-slot software timer: top level with the control sequencer and slot table.
// Depends on msst_pkg for codes and layout, and on msst_ram for the slot memory.
//
//   Channel | Direction | tdata / data fields (low bit up)                  | tuser / last
//   req_    | in        | first_timeout, repeat_timeout, timer_mode, in_seconds | tuser: func
//   rsp_    | out       | slot_id, elapsed_ms                               | tuser: kind, tlast: last
//   csr_    | in        | csr_data: tick_period_ms                          | -
//
// A tick walks the slots; it reads and writes back one memory entry at a time for an
// active slot and skips a free one. An accepted add scans up to the lowest free slot,
// runs the bit-serial divider and writes the entry; an add rejected by its mode goes
// straight to its result, one rejected for lack of a free slot after scanning all.
// Reset is synchronous and frees every slot at once; the slot memory needs no clearing.
// Results wait in one output register; while it is full, a reported fire pauses the walk.
`default_nettype none

module multi_slot_software_timer #(
   parameter int unsigned SLOT_COUNT = msst_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] first_timeout, [63:32] repeat_timeout, [65:64] timer_mode, [66] in_seconds
   input  wire logic [msst_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]                      req_tuser,
   // Result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [2:0] slot_id, [34:3] elapsed_ms
   output logic [msst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [2:0] kind
   output logic [2:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   // Configuration write: tick_period_ms
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [msst_pkg::PERIOD_W-1:0]   csr_data
);

   localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLR,
      ST_SCAN,
      ST_DIV,
      ST_ADDWR,
      ST_RSP,
      ST_TKRD,
      ST_TKWR,
      ST_TKEND
   } state_type;

   typedef struct packed {
      logic [msst_pkg::REM_W-1:0] rem;
      logic [msst_pkg::DVD_W-1:0] quo;
   } div_type;

   // Timeout in the chosen unit, scaled to milliseconds.
   function automatic logic [msst_pkg::DVD_W-1:0] to_dividend(input logic [31:0] t,
                                                               input logic secs);
      logic [msst_pkg::DVD_W-1:0] wide;
      wide = msst_pkg::DVD_W'(t);
      return secs ? msst_pkg::DVD_W'(wide * msst_pkg::DVD_W'(msst_pkg::MS_PER_SECOND))
                  : wide;
   endfunction

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   function automatic div_type div_step(input div_type cur,
                                        input logic [msst_pkg::PERIOD_W-1:0] per);
      logic [msst_pkg::REM_W-1:0] trial;
      logic [msst_pkg::REM_W-1:0] divisor;
      div_type nxt;
      trial   = {cur.rem[msst_pkg::REM_W-2:0], cur.quo[msst_pkg::DVD_W-1]};
      divisor = {1'b0, per};
      if (trial >= divisor) begin
         nxt.rem = trial - divisor;
         nxt.quo = {cur.quo[msst_pkg::DVD_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial;
         nxt.quo = {cur.quo[msst_pkg::DVD_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Quotient saturated to 32 bits.
   function automatic logic [31:0] saturate(input logic [msst_pkg::DVD_W-1:0] q);
      return (q[msst_pkg::DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   // Low three bits of a slot number, zero-extended for small tables.
   function automatic logic [2:0] slot3(input logic [IDX_W-1:0] s);
      logic [IDX_W+2:0] wide;
      wide = {3'b000, s};
      return wide[2:0];
   endfunction

   // Registers
   state_type                      state_ff, state_in;
   msst_pkg::func_type             func_ff, func_in;
   logic [31:0]                    t1_ff, t1_in;
   logic [31:0]                    t2_ff, t2_in;
   msst_pkg::mode_type             tmode_ff, tmode_in;
   logic                           secs_ff, secs_in;
   logic [msst_pkg::PERIOD_W-1:0]  period_ff, period_in;
   logic [31:0]                    uptime_ff, uptime_in;
   logic [31:0]                    ms_ff, ms_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [IDX_W-1:0]               slot_ff, slot_in;
   msst_pkg::kind_type             add_kind_ff, add_kind_in;
   msst_pkg::mode_type             mode_ff [SLOT_COUNT];
   msst_pkg::mode_type             mode_in [SLOT_COUNT];
   div_type                        diva_ff, diva_in;
   div_type                        divb_ff, divb_in;
   logic [msst_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                           pend_ff, pend_in;
   logic [IDX_W-1:0]               pend_slot_ff, pend_slot_in;
   logic [msst_pkg::REP_CNT_W-1:0] rep_cnt_ff, rep_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   msst_pkg::kind_type             rsp_kind_ff, rsp_kind_in;
   logic [2:0]                     rsp_slot_ff, rsp_slot_in;
   logic [31:0]                    rsp_ms_ff, rsp_ms_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Slot memory port signals
   logic                           ram_wr_en;
   logic [IDX_W-1:0]               ram_wr_addr;
   msst_pkg::slot_entry_type       ram_wr_data;
   logic                           ram_rd_en;
   logic [IDX_W-1:0]               ram_rd_addr;
   msst_pkg::slot_entry_type       ram_rd_data;

   // Combinational helpers
   logic                           req_accept;
   logic                           out_free;
   logic                           push;
   msst_pkg::kind_type             push_kind;
   logic [2:0]                     push_slot;
   logic [31:0]                    push_ms;
   logic                           push_last;
   logic                           add_ok;
   logic [msst_pkg::PERIOD_W-1:0]  per_conv;
   logic [47:0]                    elapsed_prod;
   msst_pkg::mode_type             walk_mode;
   logic [31:0]                    walk_cmp;
   logic                           walk_fire;
   logic                           walk_report;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign per_conv   = (period_ff == '0) ? msst_pkg::PERIOD_W'(1) : period_ff;
   assign elapsed_prod = uptime_ff * period_ff;

   // Add validation against the requested mode.
   always_comb begin
      unique case (tmode_ff)
         msst_pkg::MODE_SINGLE:        add_ok = (t1_ff != '0);
         msst_pkg::MODE_CYCLIC:        add_ok = (t2_ff != '0);
         msst_pkg::MODE_SINGLE_CYCLIC: add_ok = (t1_ff != '0) && (t2_ff != '0);
         default:                      add_ok = 1'b0;
      endcase
   end

   // Fire decision for the slot whose entry was just read.
   assign walk_mode   = mode_ff[idx_ff];
   assign walk_cmp    = (walk_mode == msst_pkg::MODE_CYCLIC) ? ram_rd_data.repeat_cmp
                                                             : ram_rd_data.first_cmp;
   assign walk_fire   = (ram_rd_data.count >= walk_cmp);
   assign walk_report = walk_fire &&
                        (rep_cnt_ff < msst_pkg::REP_CNT_W'(msst_pkg::RESULT_CAP));

   // Sequencer: next state, slot table updates, memory accesses and result pushes.
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      tmode_in     = tmode_ff;
      secs_in      = secs_ff;
      period_in    = period_ff;
      uptime_in    = uptime_ff;
      ms_in        = ms_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      add_kind_in  = add_kind_ff;
      mode_in      = mode_ff;
      diva_in      = diva_ff;
      divb_in      = divb_ff;
      div_cnt_in   = div_cnt_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      rep_cnt_in   = rep_cnt_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;
      push         = 1'b0;
      push_kind    = msst_pkg::KIND_IDLE;
      push_slot    = 3'd0;
      push_ms      = ms_ff;
      push_last    = 1'b1;

      if (csr_valid && csr_ready) begin
         period_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in  = msst_pkg::func_type'(req_tuser);
               t1_in    = req_tdata[31:0];
               t2_in    = req_tdata[63:32];
               tmode_in = msst_pkg::mode_type'(req_tdata[65:64]);
               secs_in  = req_tdata[66];
               unique case (msst_pkg::func_type'(req_tuser))
                  msst_pkg::FUNC_TICK: begin
                     uptime_in = uptime_ff + 32'd1;
                     state_in  = ST_MUL;
                  end
                  msst_pkg::FUNC_ADD: begin
                     state_in = ST_MUL;
                  end
                  msst_pkg::FUNC_CLEAR: begin
                     for (int i = 0; i < SLOT_COUNT; i++) begin
                        mode_in[i] = msst_pkg::MODE_FREE;
                     end
                     uptime_in = '0;
                     state_in  = ST_CLR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Elapsed time, divider load, walk setup and the add check against the mode.
         ST_MUL: begin
            ms_in        = elapsed_prod[31:0];
            idx_in       = '0;
            pend_in      = 1'b0;
            rep_cnt_in   = '0;
            div_cnt_in   = '0;
            diva_in.rem  = '0;
            diva_in.quo  = to_dividend(t1_ff, secs_ff);
            divb_in.rem  = '0;
            divb_in.quo  = to_dividend(t2_ff, secs_ff);
            if (func_ff == msst_pkg::FUNC_TICK) begin
               state_in = ST_TKRD;
            end else if (add_ok) begin
               state_in = ST_SCAN;
            end else begin
               add_kind_in = msst_pkg::KIND_REJECTED;
               slot_in     = '0;
               state_in    = ST_RSP;
            end
         end

         ST_CLR: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = msst_pkg::KIND_CLEARED;
               push_ms   = '0;
               state_in  = ST_IDLE;
            end
         end

         // Look for the lowest free slot, one slot per cycle.
         ST_SCAN: begin
            if (mode_ff[idx_ff] == msst_pkg::MODE_FREE) begin
               slot_in  = idx_ff;
               state_in = ST_DIV;
            end else if (idx_ff == IDX_LAST) begin
               add_kind_in = msst_pkg::KIND_REJECTED;
               slot_in     = '0;
               state_in    = ST_RSP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // Both compares are divided side by side, one quotient bit per cycle.
         ST_DIV: begin
            diva_in    = div_step(diva_ff, per_conv);
            divb_in    = div_step(divb_ff, per_conv);
            div_cnt_in = div_cnt_ff + msst_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == msst_pkg::DIV_CNT_W'(msst_pkg::DVD_W - 1)) begin
               state_in = ST_ADDWR;
            end
         end

         ST_ADDWR: begin
            ram_wr_en              = 1'b1;
            ram_wr_addr            = slot_ff;
            ram_wr_data.repeat_cmp = saturate(divb_ff.quo);
            ram_wr_data.first_cmp  = saturate(diva_ff.quo);
            ram_wr_data.count      = '0;
            mode_in[slot_ff]       = tmode_ff;
            add_kind_in            = msst_pkg::KIND_ADDED;
            state_in               = ST_RSP;
         end

         ST_RSP: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = add_kind_ff;
               push_slot = slot3(slot_ff);
               state_in  = ST_IDLE;
            end
         end

         // Walk: issue a read for an active slot, skip a free one.
         ST_TKRD: begin
            if (mode_ff[idx_ff] == msst_pkg::MODE_FREE) begin
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_TKEND;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_TKWR;
            end
         end

         // Walk: count up or fire, write back; a reported fire pushes out the previous held one.
         ST_TKWR: begin
            if (!(walk_report && pend_ff && !out_free)) begin
               ram_wr_en         = 1'b1;
               ram_wr_data.count = walk_fire ? 32'd0 : ram_rd_data.count + 32'd1;
               if (walk_fire) begin
                  mode_in[idx_ff] = (walk_mode == msst_pkg::MODE_SINGLE) ?
                                    msst_pkg::MODE_FREE : msst_pkg::MODE_CYCLIC;
               end
               if (walk_report) begin
                  if (pend_ff) begin
                     push      = 1'b1;
                     push_kind = msst_pkg::KIND_FIRED;
                     push_slot = slot3(pend_slot_ff);
                     push_last = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = idx_ff;
                  rep_cnt_in   = rep_cnt_ff + msst_pkg::REP_CNT_W'(1);
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_TKEND;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_TKRD;
               end
            end
         end

         // Final result of a tick: the held fire, or a tick without fire.
         ST_TKEND: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = pend_ff ? msst_pkg::KIND_FIRED : msst_pkg::KIND_IDLE;
               push_slot = pend_ff ? slot3(pend_slot_ff) : 3'd0;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_ms_in    = rsp_ms_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = push_kind;
         rsp_slot_in  = push_slot;
         rsp_ms_in    = push_ms;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= msst_pkg::PERIOD_W'(1);
         uptime_ff    <= '0;
         pend_ff      <= 1'b0;
         rep_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            mode_ff[i] <= msst_pkg::MODE_FREE;
         end
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         uptime_ff    <= uptime_in;
         pend_ff      <= pend_in;
         rep_cnt_ff   <= rep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
      func_ff      <= func_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      tmode_ff     <= tmode_in;
      secs_ff      <= secs_in;
      ms_ff        <= ms_in;
      idx_ff       <= idx_in;
      slot_ff      <= slot_in;
      add_kind_ff  <= add_kind_in;
      diva_ff      <= diva_in;
      divb_ff      <= divb_in;
      div_cnt_ff   <= div_cnt_in;
      pend_slot_ff <= pend_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ms_ff    <= rsp_ms_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Slot memory: count and both compares per slot.
   msst_ram #(
      .WIDTH(msst_pkg::ENTRY_W),
      .DEPTH(SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_ms_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // No more fires are held for reporting than the result cap.
   assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= msst_pkg::REP_CNT_W'(msst_pkg::RESULT_CAP))
      else $error("fire report count beyond cap");

   // A tick transaction advances the uptime by one.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == msst_pkg::FUNC_TICK) |=> uptime_ff == $past(uptime_ff) + 32'd1)
      else $error("tick did not advance uptime");

   // A clear transaction zeroes the uptime and frees the first slot.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == msst_pkg::FUNC_CLEAR) |=>
         (uptime_ff == '0) && (mode_ff[0] == msst_pkg::MODE_FREE))
      else $error("clear left state behind");

   // Read data from the slot memory is always consumed by the write-back step.
   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> state_ff == ST_TKWR)
      else $error("slot read without write-back");
`endif

endmodule

`default_nettype wire
